// ----- src/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator: sizes, mode
// codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int NUM_BLOCKS = 32768;
	localparam int BS_LOG2    = 12;
	localparam int ADDR_W     = 32;
	localparam int FIRST_W    = ADDR_W - BS_LOG2;
	localparam int BLK_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = 16;
	localparam int WORD_W     = 32;
	localparam int WORDS      = NUM_BLOCKS / WORD_W;
	localparam int WORD_AW    = $clog2(WORDS);
	localparam int MODE_W     = 3;
	localparam int PADDR_W    = 3;

	localparam logic [MODE_W-1:0] MODE_INIT    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RFREE   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RRSV    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FREE    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_TEST    = 3'd5;

	localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(NUM_BLOCKS);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_FILL,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_ZERO_RD,
		ST_ZERO_WR,
		ST_SCAN_RD,
		ST_SCAN_STEP,
		ST_ALLOC_MARK,
		ST_TEST_RD,
		ST_TEST_CAP,
		ST_DONE
	} bba_state_t;

	typedef struct packed {
		logic load;
		logic fill_we;
		logic word_ld_start;
		logic word_clr;
		logic rd_en;
		logic mark_wr;
		logic zero_wr;
		logic test_cap;
		logic scan_step;
		logic alloc_set;
		logic init_count;
		logic finish;
	} bba_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic fill_last;
		logic mark_last;
		logic mark_empty;
		logic tot_nz;
		logic alloc_reject;
		logic test_in_range;
		logic scan_found;
		logic scan_stop;
		logic byte_last;
		logic word_last;
		logic out_busy;
	} bba_stat_t;

endpackage

// ----- src/bba_ram.sv -----
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/bba_ctrl.sv -----
// ----------------------------------------------------------------------------
// bba_ctrl
// Controller: sequences the clear pass, mode dispatch, word read-modify-write
// passes, the first-fit scan and the result handoff.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  bba_stat_t stat,
	output bba_cmd_t  cmd
);

	bba_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.fill_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (stat.mode)
					MODE_INIT: state_d = ST_FILL;
					MODE_RFREE, MODE_RRSV, MODE_FREE: begin
						if (!stat.mark_empty) state_d = ST_MARK_RD;
						else if (stat.mode == MODE_RFREE && stat.tot_nz) state_d = ST_ZERO_RD;
						else state_d = ST_DONE;
					end
					MODE_ALLOC: state_d = stat.alloc_reject ? ST_DONE : ST_SCAN_RD;
					MODE_TEST: state_d = stat.test_in_range ? ST_TEST_RD : ST_DONE;
					default: state_d = ST_DONE;
				endcase
			end
			ST_FILL: begin
				if (stat.fill_last) state_d = ST_DONE;
			end
			ST_MARK_RD: state_d = ST_MARK_WR;
			ST_MARK_WR: begin
				if (!stat.mark_last) state_d = ST_MARK_RD;
				else if (stat.mode == MODE_RFREE && stat.tot_nz) state_d = ST_ZERO_RD;
				else state_d = ST_DONE;
			end
			ST_ZERO_RD: state_d = ST_ZERO_WR;
			ST_ZERO_WR: state_d = ST_DONE;
			ST_SCAN_RD: state_d = ST_SCAN_STEP;
			ST_SCAN_STEP: begin
				if (stat.scan_found) state_d = ST_ALLOC_MARK;
				else if (stat.scan_stop) state_d = ST_DONE;
				else if (stat.byte_last && stat.word_last) state_d = ST_DONE;
				else if (stat.byte_last) state_d = ST_SCAN_RD;
			end
			ST_ALLOC_MARK: state_d = ST_MARK_RD;
			ST_TEST_RD: state_d = ST_TEST_CAP;
			ST_TEST_CAP: state_d = ST_DONE;
			ST_DONE: begin
				if (!stat.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.fill_we = 1'b1;
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load = req_valid;
			end
			ST_DISPATCH: begin
				case (stat.mode)
					MODE_INIT: cmd.init_count = 1'b1;
					MODE_RFREE, MODE_RRSV, MODE_FREE: begin
						if (!stat.mark_empty) cmd.word_ld_start = 1'b1;
						else cmd.word_clr = 1'b1;
					end
					MODE_TEST: cmd.word_ld_start = 1'b1;
					default: cmd = '0;
				endcase
			end
			ST_FILL: cmd.fill_we = 1'b1;
			ST_MARK_RD, ST_ZERO_RD, ST_SCAN_RD, ST_TEST_RD: cmd.rd_en = 1'b1;
			ST_MARK_WR: begin
				cmd.mark_wr = 1'b1;
				cmd.word_clr = stat.mark_last;
			end
			ST_ZERO_WR: cmd.zero_wr = 1'b1;
			ST_SCAN_STEP: begin
				cmd.scan_step = 1'b1;
				cmd.alloc_set = stat.scan_found;
			end
			ST_ALLOC_MARK: cmd.word_ld_start = 1'b1;
			ST_TEST_CAP: cmd.test_cap = 1'b1;
			ST_DONE: cmd.finish = !stat.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

// ----- src/bba_datapath.sv -----
// ----------------------------------------------------------------------------
// bba_datapath
// Datapath: bitmap RAM, word pointer, run and count registers, word masks
// for run marking, the byte-wide first-fit scan and the result registers.
// ----------------------------------------------------------------------------
module bba_datapath import bba_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  bba_cmd_t            cmd,
	output bba_stat_t           stat,
	input  logic [CNT_W-1:0]    tot_eff,
	input  logic [MODE_W-1:0]   mode,
	input  logic [ADDR_W-1:0]   address,
	input  logic [ADDR_W-1:0]   byte_length,
	input  logic [CNT_W-1:0]    block_count,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic                ok,
	output logic [ADDR_W-1:0]   alloc_address,
	output logic                block_used,
	output logic [CNT_W-1:0]    used_total
);

	// operation registers
	logic [MODE_W-1:0]  mode_q;
	logic [FIRST_W-1:0] start_q;
	logic [CNT_W-1:0]   end_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   tot_q;
	logic [CNT_W-1:0]   run_q;
	logic [1:0]         bit_q;
	logic [WORD_AW-1:0] word_q;
	logic [CNT_W-1:0]   used_q;
	logic               res_ok_q;
	logic               res_bused_q;
	logic [ADDR_W-1:0]  res_addr_q;
	logic               out_valid_q;

	// RAM
	logic               ram_we;
	logic [WORD_W-1:0]  ram_wdata;
	logic [WORD_W-1:0]  rdata;

	// load setup
	logic [FIRST_W-1:0] in_first;
	logic [FIRST_W-1:0] in_len;
	logic [FIRST_W:0]   in_end_raw;
	logic [CNT_W-1:0]   in_end;

	// mark
	logic [WORD_AW-1:0] ws, we_idx;
	logic [CNT_W-1:0]   endm1;
	logic [4:0]         lo, hi;
	logic [WORD_W-1:0]  mask;
	logic [5:0]         nbits;
	logic [WORD_W-1:0]  mark_word;
	logic               mark_val;
	logic [CNT_W:0]     used_sum;
	logic [CNT_W-1:0]   used_mark;

	// scan
	logic [BLK_W-1:0]   scan_base;
	logic [CNT_W-1:0]   scan_run;
	logic               scan_found;
	logic               scan_stop;
	logic [CNT_W-1:0]   scan_pos;
	logic [CNT_W-1:0]   alloc_start;

	// decode the new item
	always_comb begin
		in_first = address[ADDR_W-1:BS_LOG2];
		if (mode == MODE_FREE) in_len = FIRST_W'(block_count);
		else in_len = byte_length[ADDR_W-1:BS_LOG2];
		in_end_raw = {1'b0, in_first} + {1'b0, in_len};
		if (in_end_raw > (FIRST_W+1)'(tot_eff)) in_end = tot_eff;
		else in_end = in_end_raw[CNT_W-1:0];
	end

	// run mask within the current word
	always_comb begin
		ws       = start_q[BLK_W-1:5];
		endm1    = end_q - CNT_W'(1);
		we_idx   = endm1[BLK_W-1:5];
		lo       = (word_q == ws) ? start_q[4:0] : 5'd0;
		hi       = (word_q == we_idx) ? endm1[4:0] : 5'd31;
		mask     = ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (5'd31 - hi));
		nbits    = {1'b0, hi} - {1'b0, lo} + 6'd1;
		mark_val = (mode_q == MODE_RRSV) || (mode_q == MODE_ALLOC);
		mark_word = mark_val ? (rdata | mask) : (rdata & ~mask);
		used_sum = {1'b0, used_q} + (CNT_W+1)'(nbits);
		if (mark_val) begin
			if (used_q >= tot_q) used_mark = used_q;
			else if (used_sum > {1'b0, tot_q}) used_mark = tot_q;
			else used_mark = used_sum[CNT_W-1:0];
		end else begin
			if (used_q > CNT_W'(nbits)) used_mark = used_q - CNT_W'(nbits);
			else used_mark = '0;
		end
	end

	// first-fit scan over one byte of the word
	always_comb begin
		logic [CNT_W-1:0] bidx;
		logic             used_bit;
		scan_base  = {word_q, bit_q, 3'b000};
		scan_run   = run_q;
		scan_found = 1'b0;
		scan_stop  = 1'b0;
		scan_pos   = '0;
		for (int j = 0; j < 8; j++) begin
			bidx     = CNT_W'(scan_base) + CNT_W'(j);
			used_bit = rdata[{bit_q, 3'(j)}];
			if (!scan_found && !scan_stop) begin
				if (bidx >= tot_q) begin
					scan_stop = 1'b1;
				end else if (used_bit) begin
					scan_run = '0;
				end else begin
					scan_run = scan_run + CNT_W'(1);
					if (scan_run == cnt_q) begin
						scan_found = 1'b1;
						scan_pos   = bidx;
					end
				end
			end
		end
		alloc_start = scan_pos + CNT_W'(1) - cnt_q;
	end

	// RAM write data
	always_comb begin
		ram_we    = cmd.fill_we || cmd.mark_wr || cmd.zero_wr;
		ram_wdata = {WORD_W{1'b1}};
		if (cmd.mark_wr) ram_wdata = mark_word;
		else if (cmd.zero_wr) ram_wdata = rdata | WORD_W'(1);
	end

	bba_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (word_q),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (word_q),
		.rdata (rdata)
	);

	// word pointer, count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q      <= '0;
			used_q      <= TOTAL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load || cmd.word_clr) word_q <= '0;
			else if (cmd.word_ld_start) word_q <= start_q[BLK_W-1:5];
			else if (cmd.fill_we || cmd.mark_wr) word_q <= word_q + WORD_AW'(1);
			else if (cmd.scan_step && bit_q == 2'd3 && !scan_found) word_q <= word_q + WORD_AW'(1);

			if (cmd.init_count) used_q <= tot_q;
			else if (cmd.mark_wr) used_q <= used_mark;

			if (cmd.finish) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	// operation and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q      <= mode;
			start_q     <= in_first;
			end_q       <= in_end;
			cnt_q       <= block_count;
			tot_q       <= tot_eff;
			run_q       <= '0;
			bit_q       <= '0;
			res_ok_q    <= (mode <= MODE_TEST) && (mode != MODE_ALLOC);
			res_bused_q <= (mode == MODE_TEST) && (in_first >= FIRST_W'(tot_eff));
			res_addr_q  <= '0;
		end else begin
			if (cmd.scan_step) begin
				run_q <= scan_run;
				bit_q <= bit_q + 2'd1;
			end
			if (cmd.alloc_set) begin
				start_q    <= FIRST_W'(alloc_start);
				end_q      <= scan_pos + CNT_W'(1);
				res_ok_q   <= 1'b1;
				res_addr_q <= {{(FIRST_W-BLK_W){1'b0}}, alloc_start[BLK_W-1:0],
					{BS_LOG2{1'b0}}};
			end
			if (cmd.test_cap) res_bused_q <= rdata[start_q[4:0]];
		end
		if (cmd.finish) begin
			ok            <= res_ok_q;
			alloc_address <= res_addr_q;
			block_used    <= res_bused_q;
			used_total    <= used_q;
		end
	end

	// status
	always_comb begin
		stat.mode          = mode_q;
		stat.fill_last     = (word_q == WORD_AW'(WORDS-1));
		stat.mark_last     = (word_q == we_idx);
		stat.mark_empty    = (start_q >= FIRST_W'(end_q));
		stat.tot_nz        = (tot_q != '0);
		stat.alloc_reject  = (cnt_q == '0) || (used_q >= tot_q) || ((tot_q - used_q) < cnt_q);
		stat.test_in_range = (start_q < FIRST_W'(tot_q));
		stat.scan_found    = scan_found;
		stat.scan_stop     = scan_stop;
		stat.byte_last     = (bit_q == 2'd3);
		stat.word_last     = (word_q == WORD_AW'(WORDS-1));
		stat.out_busy      = out_valid_q && !rsp_ready;
	end

	assign rsp_valid = out_valid_q;

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(NUM_BLOCKS))
		else $error("used count above capacity");

	a_alloc_span: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_set |=> (end_q - start_q[CNT_W-1:0]) == cnt_q)
		else $error("allocated run length mismatch");

	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_wr |-> (word_q >= ws && word_q <= we_idx))
		else $error("mark write outside run");
`endif

endmodule

// ----- src/bitmap_block_allocator.sv -----
// Operation: init writes every bitmap word; region/free marking reads and writes
// back each bitmap word touched; alloc scans each 32-block word with one RAM read and
// four byte steps, then marks the run; test reads one word. One item at a time.
// Throughput is set by the word-by-word walk over the 1024-word bitmap RAM.
// Reset: asynchronous; after reset a clear pass sets every bitmap word to
// all ones before the first word is accepted; configuration is taken at once.
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit bitmap block allocator with an APB register for the block total.
// ----------------------------------------------------------------------------
module bitmap_block_allocator import bba_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [MODE_W-1:0]  mode,
	input  logic [ADDR_W-1:0]  address,
	input  logic [ADDR_W-1:0]  byte_length,
	input  logic [CNT_W-1:0]   block_count,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic               ok,
	output logic [ADDR_W-1:0]  alloc_address,
	output logic               block_used,
	output logic [CNT_W-1:0]   used_total
);

	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] tot_eff;
	bba_cmd_t         cmd;
	bba_stat_t        stat;

	// total register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			total_q <= pwdata[CNT_W-1:0];
		end
	end

	assign pready  = 1'b1;
	assign prdata  = paddr[2] ? 32'd0 : {{(32-CNT_W){1'b0}}, total_q};
	assign tot_eff = (total_q > TOTAL_RESET) ? TOTAL_RESET : total_q;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bba_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.tot_eff       (tot_eff),
		.mode          (mode),
		.address       (address),
		.byte_length   (byte_length),
		.block_count   (block_count),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.ok            (ok),
		.alloc_address (alloc_address),
		.block_used    (block_used),
		.used_total    (used_total)
	);

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap block allocator. A scoreboard keeps its
// own copy of the usage bitmap, the used count and the total register and
// predicts every response word; directed and random command streams run over
// several block totals while both handshakes idle at random in all but the last two random phases.
// ----------------------------------------------------------------------------
module tb_top;
	import bba_pkg::*;

	localparam int LIMIT_CYCLES = 20000000;
	localparam int HOLD_CYCLES  = 400;

	typedef struct {
		logic              ok;
		logic [ADDR_W-1:0] alloc_address;
		logic              block_used;
		logic [CNT_W-1:0]  used_total;
	} alloc_rsp_t;

	// predicts allocator responses and compares the ones returned
	class alloc_scoreboard;
		bit               used_map [NUM_BLOCKS];
		logic [CNT_W-1:0] used_cnt;
		logic [CNT_W-1:0] total;
		alloc_rsp_t       rsp_q[$];
		int               errors;

		function new();
			foreach (used_map[i]) used_map[i] = 1'b1;
			total    = TOTAL_RESET;
			used_cnt = TOTAL_RESET;
			errors   = 0;
		endfunction

		function int eff_total();
			return (total > NUM_BLOCKS) ? NUM_BLOCKS : int'(total);
		endfunction

		// write a run clipped to the total, stepping the count per block
		function void mark_run(longint start, longint n, bit v);
			longint stop;
			int t;
			t = eff_total();
			stop = start + n;
			if (stop > t) stop = t;
			for (longint b = start; b < stop; b++) begin
				used_map[b] = v;
				if (v) begin
					if (used_cnt < t) used_cnt++;
				end else if (used_cnt > 0) used_cnt--;
			end
		endfunction

		function void note_request(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a,
				logic [ADDR_W-1:0] len, logic [CNT_W-1:0] cnt);
			alloc_rsp_t r;
			longint first;
			int t, freeb, run, b;
			bit found;
			t = eff_total();
			first = a >> BS_LOG2;
			r = '{ok: 1'b1, alloc_address: '0, block_used: 1'b0, used_total: '0};
			case (m)
				MODE_INIT: begin
					foreach (used_map[i]) used_map[i] = 1'b1;
					used_cnt = CNT_W'(t);
				end
				MODE_RFREE: begin
					mark_run(first, len >> BS_LOG2, 1'b0);
					if (t > 0) used_map[0] = 1'b1;
				end
				MODE_RRSV: mark_run(first, len >> BS_LOG2, 1'b1);
				MODE_ALLOC: begin
					r.ok = 1'b0;
					freeb = (used_cnt < t) ? t - int'(used_cnt) : 0;
					if (cnt != 0 && freeb >= cnt) begin
						run = 0;
						found = 0;
						for (b = 0; b < t; b++) begin
							if (used_map[b]) run = 0;
							else begin
								run++;
								if (run == cnt) begin
									found = 1;
									break;
								end
							end
						end
						if (found) begin
							mark_run(b + 1 - cnt, cnt, 1'b1);
							r.ok = 1'b1;
							r.alloc_address = ADDR_W'(longint'(b + 1 - cnt) << BS_LOG2);
						end
					end
				end
				MODE_FREE: mark_run(first, cnt, 1'b0);
				MODE_TEST: r.block_used = (first < t) ? used_map[first] : 1'b1;
				default: r.ok = 1'b0;
			endcase
			r.used_total = used_cnt;
			rsp_q.push_back(r);
		endfunction

		function void check_result(alloc_rsp_t got);
			alloc_rsp_t e;
			if (rsp_q.size() == 0) begin
				$error("response word with nothing expected");
				errors++;
				return;
			end
			e = rsp_q.pop_front();
			if (got.ok !== e.ok) begin
				$error("ok: expected %0d, got %0d", e.ok, got.ok);
				errors++;
			end
			if (got.alloc_address !== e.alloc_address) begin
				$error("alloc_address: expected %0h, got %0h", e.alloc_address,
					got.alloc_address);
				errors++;
			end
			if (got.block_used !== e.block_used) begin
				$error("block_used: expected %0d, got %0d", e.block_used, got.block_used);
				errors++;
			end
			if (got.used_total !== e.used_total) begin
				$error("used_total: expected %0d, got %0d", e.used_total, got.used_total);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               req_valid, req_ready;
	logic [MODE_W-1:0]  mode;
	logic [ADDR_W-1:0]  address, byte_length;
	logic [CNT_W-1:0]   block_count;
	logic               rsp_valid, rsp_ready;
	logic               ok, block_used;
	logic [ADDR_W-1:0]  alloc_address;
	logic [CNT_W-1:0]   used_total;

	alloc_scoreboard sb;
	int tx_idle, rx_idle;
	int hold_reqs, hold_seen, hold_left;
	int cycles;

	bitmap_block_allocator DUT (.*);

	// clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// count cycles, give up at the limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stalls plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else
			rsp_ready <= ($urandom_range(99) >= rx_idle);
	end

	// check each accepted response word
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_result('{ok, alloc_address, block_used, used_total});
	end

	task automatic apb_write(logic [31:0] v);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= '0;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.total = v[CNT_W-1:0];
	endtask

	// offer one word, hold it until accepted, then note it
	task automatic send(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a,
			logic [ADDR_W-1:0] len, logic [CNT_W-1:0] cnt);
		if ($urandom_range(99) < tx_idle) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle);
		end
		req_valid   <= 1'b1;
		mode        <= m;
		address     <= a;
		byte_length <= len;
		block_count <= cnt;
		do @(posedge clk); while (!req_ready);
		sb.note_request(m, a, len, cnt);
	endtask

	// drain outstanding responses, then let the block settle
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.rsp_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// random word biased toward blocks below the total
	task automatic send_random(int t);
		logic [MODE_W-1:0] m;
		logic [ADDR_W-1:0] a, len;
		logic [CNT_W-1:0]  cnt;
		int r;
		r = $urandom_range(99);
		if (r < 30)      m = MODE_ALLOC;
		else if (r < 50) m = MODE_FREE;
		else if (r < 65) m = MODE_RFREE;
		else if (r < 80) m = MODE_RRSV;
		else if (r < 95) m = MODE_TEST;
		else if (r < 97) m = MODE_INIT;
		else             m = MODE_W'($urandom_range(6, 7));
		if ($urandom_range(99) < 85)
			a = ($urandom_range(0, t + 4) << BS_LOG2) | $urandom_range(0, 4095);
		else
			a = $urandom;
		if ($urandom_range(99) < 85)
			len = ($urandom_range(0, t / 4 + 2) << BS_LOG2) | $urandom_range(0, 4095);
		else
			len = $urandom;
		if ($urandom_range(99) < 90)
			cnt = CNT_W'($urandom_range(0, t / 8 + 3));
		else
			cnt = CNT_W'($urandom_range(0, 65535));
		send(m, a, len, cnt);
	endtask

	int totals[8] = '{37, 64, 1, 200, 1000, 2047, 33, 32768};

	initial begin
		sb = new();
		cycles = 0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		req_valid = 1'b0; mode = MODE_INIT; address = '0; byte_length = '0;
		block_count = '0; rsp_ready = 1'b0;
		tx_idle = 38; rx_idle = 72;
		hold_reqs = 0; hold_seen = 0; hold_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default total, bitmap fully used after reset
		send(MODE_TEST, 32'h0, 32'h0, 16'd0);
		send(MODE_ALLOC, 32'h0, 32'h0, 16'd1);
		send(MODE_RFREE, 32'h0, 32'h0004_0000, 16'd0);
		send(MODE_TEST, 32'h0000_5000, 32'h0, 16'd0);
		send(MODE_TEST, 32'h0, 32'h0, 16'd0);
		send(MODE_ALLOC, 32'h0, 32'h0, 16'd0);
		send(MODE_ALLOC, 32'h0, 32'h0, 16'd3);
		send(MODE_ALLOC, 32'h0, 32'h0, 16'd1000);
		send(MODE_FREE, 32'h0000_A000, 32'h0, 16'd2);
		send(MODE_RRSV, 32'h0000_1FFF, 32'h0000_2FFF, 16'd0);
		send(MODE_ALLOC, 32'h0, 32'h0, 16'd5);
		send(MODE_TEST, 32'hFFFF_FFFF, 32'h0, 16'd0);
		send(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send(3'd7, 32'h0, 32'h0, 16'd0);
		send(MODE_RFREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
		send(MODE_RFREE, 32'h0, 32'hFFFF_FFFF, 16'd0);
		send(MODE_ALLOC, 32'h0, 32'h0, 16'd32767);
		send(MODE_ALLOC, 32'h0, 32'h0, 16'd1);
		send(MODE_FREE, 32'h0, 32'h0, 16'hFFFF);
		send(MODE_RRSV, 32'h0, 32'hFFFF_FFFF, 16'd0);
		send(MODE_INIT, 32'h0, 32'h0, 16'd0);
		drain();

		// directed: zero total, then a total past the bitmap size
		apb_write(32'd0);
		send(MODE_RFREE, 32'h0, 32'h0010_0000, 16'd0);
		send(MODE_ALLOC, 32'h0, 32'h0, 16'd1);
		send(MODE_TEST, 32'h0, 32'h0, 16'd0);
		send(MODE_FREE, 32'h0, 32'h0, 16'd4);
		drain();
		apb_write(32'd65535);
		send(MODE_FREE, 32'h0000_3000, 32'h0, 16'd8);
		send(MODE_ALLOC, 32'h0, 32'h0, 16'd4);
		drain();

		// random phases over several totals; used count may exceed a lowered total
		for (int p = 0; p < 8; p++) begin
			if (p == 3) begin
				tx_idle = 72; rx_idle = 38;
			end else if (p == 6) begin
				tx_idle = 0; rx_idle = 0;
			end
			apb_write(totals[p]);
			for (int i = 0; i < ((p == 7) ? 24 : 68); i++) begin
				if (p == 1 && i == 10) hold_reqs++;
				send_random(totals[p]);
			end
			drain();
		end

		if (sb.errors == 0 && sb.rsp_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
